[rtl/core/jse_pkg.sv]
// shared types, character codes and helpers for the json string escaper
package jse_pkg;

  localparam int unsigned CODE_W = 21;
  localparam int unsigned UNIT_W = 16;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned NSEG   = 6;

  // run segments, in emission order
  localparam int unsigned SEG_PRE_ERR = 0;
  localparam int unsigned SEG_OPEN_Q  = 1;
  localparam int unsigned SEG_BRK_ERR = 2;
  localparam int unsigned SEG_BODY    = 3;
  localparam int unsigned SEG_END_ERR = 4;
  localparam int unsigned SEG_CLOSE_Q = 5;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [2:0] {
    BM_ERR  = 3'd0,
    BM_CHAR = 3'd1,
    BM_ESC2 = 3'd2,
    BM_UNIT = 3'd3,
    BM_PAIR = 3'd4
  } body_mode_t;

  typedef struct packed {
    logic [NSEG-1:0]   mask;
    body_mode_t        mode;
    logic [7:0]        ch;
    logic [UNIT_W-1:0] u0;
    logic [UNIT_W-1:0] u1;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = 8'h30 + {4'd0, n};
    end else begin
      r = 8'h57 + {4'd0, n};
    end
    return r;
  endfunction

endpackage

[rtl/core/jse_front.sv]
// front end: utf-8 decoder and run classifier
module jse_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic [1:0]    in_tuser,
  input  logic          in_tlast,
  input  jse_pkg::q_stat_t q_stat,
  output logic          cmd_push,
  output jse_pkg::cmd_t cmd
);
  import jse_pkg::*;

  logic [CODE_W-1:0] code_accum_r, code_accum_nxt;
  logic [1:0]        bytes_left_r, bytes_left_nxt;
  logic [1:0]        seq_length_r, seq_length_nxt;

  logic              take;
  logic              has, first, last;
  logic              pre_err, brk_err, end_err;
  logic              has_body, body_bad, ok;
  logic [CODE_W-1:0] cp;
  logic [CODE_W-1:0] v;

  assign in_tready = !q_stat.full;
  assign take      = in_tvalid && in_tready;
  assign has       = in_tuser[0];
  assign first     = in_tuser[1];
  assign last      = in_tlast;

  always_comb begin
    pre_err        = first && (bytes_left_r != 2'd0);
    bytes_left_nxt = first ? 2'd0 : bytes_left_r;
    code_accum_nxt = first ? '0 : code_accum_r;
    seq_length_nxt = first ? 2'd0 : seq_length_r;
    brk_err        = 1'b0;
    has_body       = 1'b0;
    body_bad       = 1'b0;
    ok             = 1'b0;
    cp             = '0;
    if (has) begin
      if ((bytes_left_nxt != 2'd0) && (in_tdata[7:6] == 2'b10)) begin
        code_accum_nxt = {code_accum_nxt[CODE_W-7:0], in_tdata[5:0]};
        bytes_left_nxt = bytes_left_nxt - 2'd1;
        if (bytes_left_nxt == 2'd0) begin
          cp = code_accum_nxt;
          case (seq_length_nxt)
            2'd1:    ok = (cp >= 21'h80);
            2'd2:    ok = (cp >= 21'h800);
            2'd3:    ok = (cp >= 21'h10000) && (cp <= 21'h10FFFF);
            default: ok = 1'b0;
          endcase
          has_body       = 1'b1;
          body_bad       = !ok;
          code_accum_nxt = '0;
          seq_length_nxt = 2'd0;
        end
      end else begin
        brk_err        = (bytes_left_nxt != 2'd0);
        code_accum_nxt = '0;
        bytes_left_nxt = 2'd0;
        seq_length_nxt = 2'd0;
        if (!in_tdata[7]) begin
          has_body = 1'b1;
          cp       = {13'd0, in_tdata};
        end else if (in_tdata[7:5] == 3'b110) begin
          code_accum_nxt = {16'd0, in_tdata[4:0]};
          bytes_left_nxt = 2'd1;
          seq_length_nxt = 2'd1;
        end else if (in_tdata[7:4] == 4'b1110) begin
          code_accum_nxt = {17'd0, in_tdata[3:0]};
          bytes_left_nxt = 2'd2;
          seq_length_nxt = 2'd2;
        end else if (in_tdata[7:3] == 5'b11110) begin
          code_accum_nxt = {18'd0, in_tdata[2:0]};
          bytes_left_nxt = 2'd3;
          seq_length_nxt = 2'd3;
        end else begin
          has_body = 1'b1;
          body_bad = 1'b1;
        end
      end
    end
    end_err = last && (bytes_left_nxt != 2'd0);
    if (last) begin
      code_accum_nxt = '0;
      bytes_left_nxt = 2'd0;
      seq_length_nxt = 2'd0;
    end
  end

  // escape form of the decoded character
  always_comb begin
    v       = cp - 21'h10000;
    cmd.mask              = '0;
    cmd.mask[SEG_PRE_ERR] = pre_err;
    cmd.mask[SEG_OPEN_Q]  = first;
    cmd.mask[SEG_BRK_ERR] = brk_err;
    cmd.mask[SEG_BODY]    = has_body;
    cmd.mask[SEG_END_ERR] = end_err;
    cmd.mask[SEG_CLOSE_Q] = last;
    cmd.mode = BM_CHAR;
    cmd.ch   = cp[7:0];
    cmd.u0   = cp[UNIT_W-1:0];
    cmd.u1   = {6'b110111, v[9:0]};
    if (body_bad) begin
      cmd.mode = BM_ERR;
      cmd.ch   = CH_NUL;
    end else if (cp >= 21'h10000) begin
      cmd.mode = BM_PAIR;
      cmd.u0   = {6'b110110, v[19:10]};
    end else if (cp > 21'h7F) begin
      cmd.mode = BM_UNIT;
    end else if ((cp[7:0] == CH_QUOTE) || (cp[7:0] == CH_BSLASH) || (cp[7:0] == CH_SLASH)) begin
      cmd.mode = BM_ESC2;
    end else if (cp < 21'h20) begin
      cmd.mode = BM_ESC2;
      case (cp[4:0])
        5'h08:   cmd.ch = "b";
        5'h0C:   cmd.ch = "f";
        5'h0A:   cmd.ch = "n";
        5'h0D:   cmd.ch = "r";
        5'h09:   cmd.ch = "t";
        default: cmd.mode = BM_UNIT;
      endcase
    end
  end

  // items that give no characters are dropped here
  assign cmd_push = take && (cmd.mask != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_accum_r <= '0;
      bytes_left_r <= 2'd0;
      seq_length_r <= 2'd0;
    end else if (take) begin
      code_accum_r <= code_accum_nxt;
      bytes_left_r <= bytes_left_nxt;
      seq_length_r <= seq_length_nxt;
    end
  end

endmodule

[rtl/core/jse_cmd_fifo.sv]
// two-entry run queue between decoder and expander
module jse_cmd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  jse_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output jse_pkg::cmd_t    head_cmd,
  output jse_pkg::q_stat_t q_stat
);
  import jse_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign head_cmd     = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[rtl/core/jse_back.sv]
// back end: expands one run into escaped characters behind an output register
module jse_back (
  input  logic             clk,
  input  logic             rst_n,
  input  jse_pkg::cmd_t    head_cmd,
  input  jse_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic [0:0]       out_tuser,
  output logic             out_tlast
);
  import jse_pkg::*;

  cmd_t            cur_r;
  logic            cur_vld_r, cur_vld_nxt;
  logic [NSEG-1:0] rem_r, rem_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic            out_vld_r, out_vld_nxt;
  logic [7:0]      out_char_r;
  logic            out_last_r;
  logic            out_bad_r;

  logic [NSEG-1:0] seg_oh;
  logic [NSEG-1:0] rem_after;
  logic [IDX_W-1:0] len_m1;
  logic [IDX_W-1:0] j;
  logic [UNIT_W-1:0] u;
  logic [7:0]      body_ch;
  logic [7:0]      ch;
  logic            bad;
  logic            seg_done;
  logic            run_end;
  logic            emit;

  always_comb begin
    seg_oh    = rem_r & (~rem_r + 1'b1);
    rem_after = rem_r & ~seg_oh;
    case (cur_r.mode)
      BM_ESC2: len_m1 = 4'd1;
      BM_UNIT: len_m1 = 4'd5;
      BM_PAIR: len_m1 = 4'd11;
      default: len_m1 = 4'd0;
    endcase
    seg_done = !seg_oh[SEG_BODY] || (idx_r == len_m1);
    run_end  = seg_done && (rem_after == '0);
  end

  // body character at the current index
  always_comb begin
    j = (idx_r < 4'd6) ? idx_r : idx_r - 4'd6;
    u = (idx_r < 4'd6) ? cur_r.u0 : cur_r.u1;
    case (j)
      4'd0:    body_ch = CH_BSLASH;
      4'd1:    body_ch = CH_U;
      4'd2:    body_ch = hex_char(u[15:12]);
      4'd3:    body_ch = hex_char(u[11:8]);
      4'd4:    body_ch = hex_char(u[7:4]);
      default: body_ch = hex_char(u[3:0]);
    endcase
    ch  = CH_NUL;
    bad = 1'b0;
    if (seg_oh[SEG_PRE_ERR] || seg_oh[SEG_BRK_ERR] || seg_oh[SEG_END_ERR]) begin
      bad = 1'b1;
    end else if (seg_oh[SEG_OPEN_Q] || seg_oh[SEG_CLOSE_Q]) begin
      ch = CH_QUOTE;
    end else begin
      case (cur_r.mode)
        BM_ERR:  bad = 1'b1;
        BM_CHAR: ch = cur_r.ch;
        BM_ESC2: ch = (idx_r == '0) ? CH_BSLASH : cur_r.ch;
        default: ch = body_ch;
      endcase
    end
  end

  assign emit = cur_vld_r && (!out_vld_r || out_tready);
  assign pop  = !q_stat.empty && (!cur_vld_r || (emit && run_end));

  always_comb begin
    out_vld_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);
    cur_vld_nxt = cur_vld_r;
    rem_nxt     = rem_r;
    idx_nxt     = idx_r;
    if (emit) begin
      idx_nxt = seg_done ? '0 : idx_r + 1'b1;
      if (seg_done) begin
        rem_nxt = rem_after;
      end
      if (run_end) begin
        cur_vld_nxt = 1'b0;
      end
    end
    if (pop) begin
      cur_vld_nxt = 1'b1;
      rem_nxt     = head_cmd.mask;
      idx_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head_cmd;
    end
    if (emit) begin
      out_char_r <= ch;
      out_last_r <= run_end;
      out_bad_r  <= bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      rem_r     <= '0;
      idx_r     <= '0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      out_vld_r <= out_vld_nxt;
      rem_r     <= rem_nxt;
      idx_r     <= idx_nxt;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_char_r;
  assign out_tuser[0] = out_bad_r;
  assign out_tlast    = out_last_r;

endmodule

[rtl/core/json_string_escaper.sv]
// top level of the json string escaper: utf-8 bytes in, escaped json characters out
//
//  channel | dir | tdata        | tuser                              | tlast
//  --------+-----+--------------+------------------------------------+---------------
//  in_     | in  | [7:0] byte   | [0] has_byte, [1] first_of_string  | last_of_string
//  out_    | out | [7:0] char   | [0] bad_utf8                       | last_of_run
//
// one character out per cycle unless stalled; an item holds the expander until all are out
// an item is taken every cycle while the two-entry run queue has room
// a taken item goes through the run queue and the run register to the output register
// rst_n clears the decoder, the run queue, the expander and the output valid
// output stalls fill the queue and then lower in_tready
module json_string_escaper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic [1:0] in_tuser,   // [0] has_byte, [1] first_of_string
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic [0:0] out_tuser,  // [0] bad_utf8
  output logic       out_tlast
);
  import jse_pkg::*;

  cmd_t    push_cmd;
  cmd_t    head_cmd;
  q_stat_t q_stat;
  logic    cmd_push;
  logic    cmd_pop;

  jse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .cmd_push  (cmd_push),
    .cmd       (push_cmd)
  );

  jse_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (push_cmd),
    .pop      (cmd_pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  jse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_cmd   (head_cmd),
    .q_stat     (q_stat),
    .pop        (cmd_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd_push && q_stat.full))
    else $error("run queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !q_stat.empty)
    else $error("run queue read while empty");

  a_err_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == CH_NUL))
    else $error("error transfer carries a character");

  a_reset_idle: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_tvalid)
    else $error("output valid straight after reset");

endmodule

[tb/json_string_escaper_tb.sv]
// testbench for the json string escaper: escape scoreboard, stream drivers and result checks
`timescale 1ns / 1ps

module json_string_escaper_tb;
  import jse_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 20;

  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_TAB = 8'h09;
  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_FF  = 8'h0C;
  localparam logic [7:0] CTL_CR  = 8'h0D;
  localparam logic [7:0] CTL_US  = 8'h1F;
  localparam logic [7:0] CH_DEL  = 8'h7F;
  localparam logic [7:0] CH_SPC  = 8'h20;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       bad;
  } esc_char_t;

  typedef struct {
    logic [7:0] data;
    logic       has;
    logic       first;
    logic       last;
  } byte_item_t;

  class escape_scoreboard;
    logic [20:0] accum;
    logic [1:0]  left;
    logic [1:0]  seq_len;
    esc_char_t   run_chars[$];
    esc_char_t   expected_chars[$];
    int          errors;

    function new();
      accum   = '0;
      left    = '0;
      seq_len = '0;
      errors  = 0;
    endfunction

    function void put(logic [7:0] ch, logic bad);
      esc_char_t c;
      c.ch   = ch;
      c.last = 1'b0;
      c.bad  = bad;
      run_chars.insert(run_chars.size(), c);
    endfunction

    function void reset_decoder();
      accum   = '0;
      left    = '0;
      seq_len = '0;
    endfunction

    function void flag_bad();
      put(CH_NUL, 1'b1);
      reset_decoder();
    endfunction

    function logic [7:0] hex_digit(logic [3:0] d);
      return (d < 4'd10) ? 8'h30 + {4'd0, d} : 8'h61 + {4'd0, d} - 8'd10;
    endfunction

    function void put_unit(logic [15:0] u);
      put(CH_BSLASH, 1'b0);
      put(CH_U, 1'b0);
      put(hex_digit(u[15:12]), 1'b0);
      put(hex_digit(u[11:8]), 1'b0);
      put(hex_digit(u[7:4]), 1'b0);
      put(hex_digit(u[3:0]), 1'b0);
    endfunction

    function void put_code(logic [20:0] cp);
      logic [20:0] v;
      if (cp > 21'h7F) begin
        if (cp >= 21'h10000) begin
          v = cp - 21'h10000;
          put_unit(16'hD800 | {6'd0, v[19:10]});
          put_unit(16'hDC00 | {6'd0, v[9:0]});
        end else begin
          put_unit(cp[15:0]);
        end
        return;
      end
      if (cp[7:0] == CH_QUOTE || cp[7:0] == CH_BSLASH || cp[7:0] == CH_SLASH)
        put(CH_BSLASH, 1'b0);
      if (cp[7:0] >= CH_SPC) begin
        put(cp[7:0], 1'b0);
        return;
      end
      case (cp[7:0])
        CTL_BS: begin
          put(CH_BSLASH, 1'b0);
          put("b", 1'b0);
        end
        CTL_FF: begin
          put(CH_BSLASH, 1'b0);
          put("f", 1'b0);
        end
        CTL_LF: begin
          put(CH_BSLASH, 1'b0);
          put("n", 1'b0);
        end
        CTL_CR: begin
          put(CH_BSLASH, 1'b0);
          put("r", 1'b0);
        end
        CTL_TAB: begin
          put(CH_BSLASH, 1'b0);
          put("t", 1'b0);
        end
        default: put_unit(cp[15:0]);
      endcase
    endfunction

    function void complete_sequence();
      logic [20:0] cp;
      logic        ok;
      cp = accum;
      case (seq_len)
        2'd1:    ok = (cp >= 21'h80);
        2'd2:    ok = (cp >= 21'h800);
        default: ok = (cp >= 21'h10000) && (cp <= 21'h10FFFF);
      endcase
      reset_decoder();
      if (ok) put_code(cp);
      else put(CH_NUL, 1'b1);
    endfunction

    function void decode_byte(logic [7:0] b);
      if (left != 2'd0) begin
        if (b[7:6] == 2'b10) begin
          accum = {accum[14:0], b[5:0]};
          left  = left - 2'd1;
          if (left == 2'd0) complete_sequence();
          return;
        end
        flag_bad();
      end
      if (b < 8'h80) begin
        put_code({13'd0, b});
      end else if (b >= 8'hC0 && b <= 8'hDF) begin
        accum = {16'd0, b[4:0]}; left = 2'd1; seq_len = 2'd1;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        accum = {17'd0, b[3:0]}; left = 2'd2; seq_len = 2'd2;
      end else if (b >= 8'hF0 && b <= 8'hF7) begin
        accum = {18'd0, b[2:0]}; left = 2'd3; seq_len = 2'd3;
      end else begin
        flag_bad();
      end
    endfunction

    function void note_item(logic [7:0] b, logic has, logic first, logic last);
      run_chars.delete();
      if (first) begin
        if (left != 2'd0) flag_bad();
        put(CH_QUOTE, 1'b0);
      end
      if (has) decode_byte(b);
      if (last) begin
        if (left != 2'd0) flag_bad();
        put(CH_QUOTE, 1'b0);
      end
      if (run_chars.size() > 0) run_chars[run_chars.size() - 1].last = 1'b1;
      foreach (run_chars[i]) expected_chars.insert(expected_chars.size(), run_chars[i]);
    endfunction

    function void check_char(logic [7:0] ch, logic bad, logic last);
      esc_char_t want;
      if (expected_chars.size() == 0) begin
        $error("unexpected character %h (bad_utf8 %b, last_of_run %b)", ch, bad, last);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      if (ch !== want.ch) begin
        $error("out_char expected %h got %h", want.ch, ch);
        errors++;
      end
      if (bad !== want.bad) begin
        $error("bad_utf8 expected %b got %b", want.bad, bad);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run expected %b got %b", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;
  logic [1:0] in_tuser   = '0;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [0:0] out_tuser;
  logic       out_tlast;

  escape_scoreboard escapes;
  byte_item_t       stim_items[$];
  logic [7:0]       string_bytes[$];
  int unsigned      live_items;
  int unsigned      send_idle_pct = 7;
  int unsigned      recv_idle_pct = 48;
  int unsigned      cycle_count   = 0;

  json_string_escaper i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // results first, so a transfer never meets an expectation noted at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        escapes.check_char(out_tdata, out_tuser[0], out_tlast);
      if (in_tvalid && in_tready)
        escapes.note_item(in_tdata, in_tuser[0], in_tuser[1], in_tlast);
    end
  end

  function automatic void add_item(logic [7:0] data, logic has, logic first, logic last);
    byte_item_t it;
    it.data  = data;
    it.has   = has;
    it.first = first;
    it.last  = last;
    stim_items.insert(stim_items.size(), it);
    if (has || first || last) live_items++;
  endfunction

  function automatic logic [7:0] special_ascii(int unsigned idx);
    case (idx)
      0:       return CH_QUOTE;
      1:       return CH_BSLASH;
      2:       return CH_SLASH;
      3:       return CTL_BS;
      4:       return CTL_FF;
      5:       return CTL_LF;
      6:       return CTL_CR;
      7:       return CTL_TAB;
      8:       return CH_NUL;
      9:       return CTL_US;
      10:      return CH_SPC;
      default: return CH_DEL;
    endcase
  endfunction

  function automatic int unsigned seq_floor(int unsigned len);
    return (len == 2) ? 32'h80 : (len == 3) ? 32'h800 : 32'h10000;
  endfunction

  function automatic int unsigned seq_ceiling(int unsigned len);
    return (len == 2) ? 32'h7FF : (len == 3) ? 32'hFFFF : 32'h10FFFF;
  endfunction

  function automatic void append_byte(logic [7:0] b);
    string_bytes.insert(string_bytes.size(), b);
  endfunction

  function automatic void encode_utf8(logic [20:0] cp, int unsigned len);
    case (len)
      1: append_byte(cp[7:0]);
      2: begin
        append_byte({3'b110, cp[10:6]});
        append_byte({2'b10, cp[5:0]});
      end
      3: begin
        append_byte({4'b1110, cp[15:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
      default: begin
        append_byte({5'b11110, cp[20:18]});
        append_byte({2'b10, cp[17:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // mostly well-formed text, with overlong, out of range, cut short and stray bytes mixed in
  task automatic make_string();
    int unsigned nchars, r, len, cp, cut;
    logic        lead_empty, tail_empty, keep_last;
    nchars = $urandom_range(8);
    for (int n = 0; n < nchars; n++) begin
      r = $urandom_range(99);
      if (r < 35) begin
        cp = ($urandom_range(2) == 0) ? 32'(special_ascii($urandom_range(11)))
                                      : $urandom_range(127);
        encode_utf8(21'(cp), 1);
      end else if (r < 75) begin
        len = $urandom_range(4, 2);
        encode_utf8(21'($urandom_range(seq_ceiling(len), seq_floor(len))), len);
      end else if (r < 80) begin
        len = $urandom_range(4, 2);
        encode_utf8(21'($urandom_range(seq_floor(len) - 1)), len);
      end else if (r < 84) begin
        encode_utf8(21'($urandom_range(32'h1FFFFF, 32'h110000)), 4);
      end else if (r < 91) begin
        len = $urandom_range(4, 2);
        encode_utf8(21'($urandom_range(seq_ceiling(len), seq_floor(len))), len);
        cut = $urandom_range(len - 1, 1);
        repeat (cut) string_bytes.delete(string_bytes.size() - 1);
      end else begin
        append_byte(8'($urandom_range(255)));
      end
    end
    lead_empty = ($urandom_range(9) == 0);
    tail_empty = ($urandom_range(9) == 0);
    keep_last  = ($urandom_range(19) != 0);
    if (string_bytes.size() == 0) begin
      add_item(8'($urandom_range(255)), 1'b0, 1'b1, keep_last);
    end else begin
      if (lead_empty) add_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0);
      foreach (string_bytes[k]) begin
        if ($urandom_range(19) == 0) add_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0);
        add_item(string_bytes[k], 1'b1, (k == 0) && !lead_empty,
                 (k == string_bytes.size() - 1) && keep_last && !tail_empty);
      end
      if (tail_empty) add_item(8'($urandom_range(255)), 1'b0, 1'b0, keep_last);
    end
    string_bytes.delete();
  endtask

  task automatic make_random(int unsigned count);
    live_items = 0;
    while (live_items < count) make_string();
  endtask

  task automatic make_directed();
    add_item(8'h00, 1'b0, 1'b1, 1'b1);
    add_item(CH_QUOTE, 1'b1, 1'b1, 1'b0);
    add_item(CH_BSLASH, 1'b1, 1'b0, 1'b0);
    add_item(CH_SLASH, 1'b1, 1'b0, 1'b0);
    add_item(CTL_BS, 1'b1, 1'b0, 1'b0);
    add_item(CTL_FF, 1'b1, 1'b0, 1'b0);
    add_item(CTL_LF, 1'b1, 1'b0, 1'b0);
    add_item(CTL_CR, 1'b1, 1'b0, 1'b0);
    add_item(CTL_TAB, 1'b1, 1'b0, 1'b0);
    add_item(CH_NUL, 1'b1, 1'b0, 1'b0);
    add_item(CH_DEL, 1'b1, 1'b0, 1'b0);
    // two-byte and highest four-byte code points
    add_item(8'hC3, 1'b1, 1'b0, 1'b0);
    add_item(8'hA9, 1'b1, 1'b0, 1'b0);
    add_item(8'hF4, 1'b1, 1'b0, 1'b0);
    add_item(8'h8F, 1'b1, 1'b0, 1'b0);
    add_item(8'hBF, 1'b1, 1'b0, 1'b0);
    add_item(8'hBF, 1'b1, 1'b0, 1'b0);
    // overlong, stray continuation, invalid byte
    add_item(8'hC0, 1'b1, 1'b0, 1'b0);
    add_item(8'h80, 1'b1, 1'b0, 1'b0);
    add_item(8'h80, 1'b1, 1'b0, 1'b0);
    add_item(8'hFF, 1'b1, 1'b0, 1'b0);
    // broken sequence, then a surrogate in three bytes
    add_item(8'hC3, 1'b1, 1'b0, 1'b0);
    add_item(8'h41, 1'b1, 1'b0, 1'b0);
    add_item(8'hED, 1'b1, 1'b0, 1'b0);
    add_item(8'hA0, 1'b1, 1'b0, 1'b0);
    add_item(8'h80, 1'b1, 1'b0, 1'b0);
    // restart mid-sequence, truncated at end, ignored item
    add_item(8'hE2, 1'b1, 1'b0, 1'b0);
    add_item(8'h41, 1'b1, 1'b1, 1'b0);
    add_item(8'hF0, 1'b1, 1'b0, 1'b1);
    add_item(8'h5A, 1'b0, 1'b0, 1'b0);
  endtask

  // called and left at a falling edge
  task automatic send_item(byte_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it.data;
    in_tuser  <= {it.first, it.has};
    in_tlast  <= it.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_items(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    foreach (stim_items[i]) send_item(stim_items[i]);
    stim_items.delete();
  endtask

  initial begin
    escapes = new();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    make_directed();
    make_random(170);
    send_items(7, 48);

    make_random(170);
    send_items(48, 7);

    make_random(160);
    send_items(0, 0);

    in_tvalid <= 1'b0;
    while (escapes.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (escapes.errors == 0 && escapes.pending() == 0) begin
      $display("PASS");
    end else begin
      if (escapes.pending() != 0)
        $error("%0d expected characters never arrived", escapes.pending());
      $display("FAIL");
    end
    $finish;
  end

endmodule
